// ===== sv/sss_pkg.sv =====
// Shared types, constants and coil tables of the stepper step sequencer.
`timescale 1ns / 1ps

package sss_pkg;

    // Default widths of the tick counter and the pending step count.
    localparam int ELAPSED_BITS_DEF = 24;
    localparam int PENDING_BITS_DEF = 16;

    // Width of the remainder unit operands: a revolution may hold 65536 positions.
    localparam int MOD_W = 17;

    // Request kinds.
    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_PLAN_FWD = 3'd1;
    localparam logic [2:0] KIND_PLAN_BWD = 3'd2;
    localparam logic [2:0] KIND_RECAL    = 3'd3;
    localparam logic [2:0] KIND_RESET    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_STEP   = 2'd0;
    localparam logic [1:0] REG_STANDSTILL = 2'd1;
    localparam logic [1:0] REG_HALF_MODE  = 2'd2;
    localparam logic [1:0] REG_STEPS_REV  = 2'd3;

    // Configuration reset values.
    localparam logic [23:0] MIN_STEP_RST   = 24'd2000;
    localparam logic [23:0] STANDSTILL_RST = 24'd100000;
    localparam logic        HALF_MODE_RST  = 1'b1;
    localparam logic [15:0] STEPS_REV_RST  = 16'd4096;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] target_position;
        logic [15:0] offset_steps;
        logic        correct_backward;
    } t_sss_req;

    typedef struct packed {
        logic [3:0]         coil_lines;
        logic               coils_on;
        logic               stepped;
        logic [15:0]        position;
        logic               moving_forward;
        logic signed [15:0] steps_pending;
    } t_sss_res;

    // Lines switched on by a phase.
    function automatic logic [3:0] phase_set(input logic half, input logic [3:0] phase);
        logic [3:0] v;
        v = 4'h0;
        if (half) begin
            unique case (phase)
                4'd1:    v = 4'h1;
                4'd2:    v = 4'h3;
                4'd3:    v = 4'h2;
                4'd4:    v = 4'h6;
                4'd5:    v = 4'h4;
                4'd6:    v = 4'hC;
                4'd7:    v = 4'h8;
                4'd8:    v = 4'h9;
                default: v = 4'h0;
            endcase
        end else begin
            unique case (phase)
                4'd1:    v = 4'h1;
                4'd2:    v = 4'h2;
                4'd3:    v = 4'h4;
                4'd4:    v = 4'h8;
                default: v = 4'h0;
            endcase
        end
        return v;
    endfunction

    // Lines switched off by a phase.
    function automatic logic [3:0] phase_clr(input logic half, input logic [3:0] phase);
        logic [3:0] v;
        v = 4'h0;
        if (half) begin
            unique case (phase)
                4'd1, 4'd5: v = 4'hA;
                4'd3, 4'd7: v = 4'h5;
                default:    v = 4'h0;
            endcase
        end else begin
            unique case (phase)
                4'd1, 4'd3: v = 4'hA;
                4'd2, 4'd4: v = 4'h5;
                default:    v = 4'h0;
            endcase
        end
        return v;
    endfunction

endpackage

// ===== sv/sss_mod_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module sss_mod_unit
    import sss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MOD_W-1:0] i_dividend,
    input  logic [MOD_W-1:0] i_divisor,
    output logic             o_done,
    output logic [MOD_W-2:0] o_rem
);

    localparam int CNT_W = $clog2(MOD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MOD_W-1:0] r_dvd;
    logic [MOD_W-2:0] r_rem;

    logic [MOD_W-1:0] w_shift;
    logic [MOD_W-1:0] w_diff;
    logic             w_ge;

    // The partial remainder stays below the divisor, so it fits one bit less.
    assign w_shift = {r_rem, r_dvd[MOD_W-1]};
    assign w_ge    = (w_shift >= i_divisor);
    assign w_diff  = w_shift - i_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MOD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[MOD_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[MOD_W-2:0] : w_shift[MOD_W-2:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== sv/stepper_step_sequencer_unit.sv =====
// Top level of the four-coil stepper step sequencer with its register port.
`timescale 1ns / 1ps

// Four-coil unipolar stepper sequencer. Each request is a tick, a plan of one
// step forward or backward, a recalibration or a reset, and each request gives
// exactly one result carrying the coil line levels, the position, the pending
// step count and whether this request moved the motor. Tick, plan, reset and
// unused kinds are finished in the cycle they are accepted: the result is valid
// from the next cycle on, or, if an earlier result is still waiting in the
// output register, from the cycle after that earlier result is taken. A
// recalibration goes through a shared restoring remainder unit that retires one
// bit per cycle; a backward correction uses it once and a forward correction
// twice, once for the target and once for the offset. Requests are stalled
// while a recalibration or a held result is in progress. Configuration is
// written through the APB port at byte addresses 0, 4, 8 and 12 and must only be
// changed while the block is idle; a revolution size of zero stands for 65536
// positions.

module stepper_step_sequencer_unit
    import sss_pkg::*;
#(
    parameter int ELAPSED_BITS = ELAPSED_BITS_DEF,
    parameter int PENDING_BITS = PENDING_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_sss_req    i_in_req,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_sss_res    o_out_res,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CMP_W = (ELAPSED_BITS > 24) ? ELAPSED_BITS : 24;
    localparam int SUM_W = ((PENDING_BITS > 17) ? PENDING_BITS : 17) + 1;

    localparam logic signed [PENDING_BITS-1:0] P_MAX = {1'b0, {(PENDING_BITS-1){1'b1}}};
    localparam logic signed [PENDING_BITS-1:0] P_MIN = {1'b1, {(PENDING_BITS-1){1'b0}}};

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MOD_A = 2'd1;
    localparam logic [1:0] S_MOD_B = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    // Configuration registers.
    logic [23:0] r_min_step;
    logic [23:0] r_standstill;
    logic        r_half;
    logic [15:0] r_spr;

    // Motor state.
    logic [3:0]                     r_phase,    n_phase;
    logic [3:0]                     r_lines,    n_lines;
    logic                           r_energized, n_energized;
    logic [15:0]                    r_pos,      n_pos;
    logic signed [PENDING_BITS-1:0] r_pend,     n_pend;
    logic [ELAPSED_BITS-1:0]        r_ticks,    n_ticks;
    logic                           r_dir,      n_dir;

    // Sequencer and result holding.
    logic [1:0]  r_state,     n_state;
    logic        r_stepped,   n_stepped;
    logic        r_out_valid, n_out_valid;
    t_sss_res    r_out,       n_out;
    logic [15:0] r_offset,    n_offset;
    logic        r_backward,  n_backward;
    logic [15:0] r_tmod,      n_tmod;

    // Remainder unit handshake.
    logic             w_mod_start;
    logic [MOD_W-1:0] w_mod_dvd;
    logic             w_mod_done;
    logic [MOD_W-2:0] w_mod_rem;

    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_cfg_wr;
    logic [16:0]                    w_rev;
    logic [ELAPSED_BITS-1:0]        w_t1;
    logic                           w_pend_zero;
    logic                           w_fwd;
    logic [3:0]                     w_top;
    logic [3:0]                     w_ph_inc;
    logic [3:0]                     w_ph_dec;
    logic [3:0]                     w_ph_new;
    logic [15:0]                    w_pos_new;
    logic [3:0]                     w_lines_new;
    logic signed [PENDING_BITS-1:0] w_pend_step;
    logic signed [SUM_W-1:0]        w_delta;
    logic signed [SUM_W-1:0]        w_pend_sum;
    logic signed [PENDING_BITS-1:0] w_pend_sat;
    logic                           w_above_standstill;
    logic                           w_below_min;
    logic [16:0]                    w_combine;
    logic                           w_stepped_now;

    // ------------------------------------------------------------------
    // Configuration port. Writes land on the access phase; reads return
    // the register addressed, zero extended.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_step   <= MIN_STEP_RST;
            r_standstill <= STANDSTILL_RST;
            r_half       <= HALF_MODE_RST;
            r_spr        <= STEPS_REV_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_MIN_STEP:   r_min_step   <= pwdata[23:0];
                REG_STANDSTILL: r_standstill <= pwdata[23:0];
                REG_HALF_MODE:  r_half       <= pwdata[0];
                REG_STEPS_REV:  r_spr        <= pwdata[15:0];
                default:        r_min_step   <= r_min_step;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MIN_STEP:   prdata = {8'd0, r_min_step};
            REG_STANDSTILL: prdata = {8'd0, r_standstill};
            REG_HALF_MODE:  prdata = {31'd0, r_half};
            REG_STEPS_REV:  prdata = {16'd0, r_spr};
            default:        prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Step arithmetic, all worked out from the current state.
    // ------------------------------------------------------------------
    assign w_rev       = (r_spr == 16'd0) ? 17'h10000 : {1'b0, r_spr};
    assign w_t1        = (r_ticks != '1) ? r_ticks + ELAPSED_BITS'(1) : r_ticks;
    assign w_pend_zero = (r_pend == '0);
    assign w_fwd       = !r_pend[PENDING_BITS-1] && !w_pend_zero;
    assign w_top       = r_half ? 4'd8 : 4'd4;

    // A phase left out of range by a change of mode restarts at the end of the
    // sequence it enters from: phase 1 going forward, the last phase going backward.
    assign w_ph_inc = r_phase + 4'd1;
    assign w_ph_dec = r_phase - 4'd1;

    always_comb begin
        if (w_fwd) begin
            w_ph_new  = (w_ph_inc > w_top || w_ph_inc == 4'd0) ? 4'd1 : w_ph_inc;
            w_pos_new = ({1'b0, r_pos} >= w_rev - 17'd1) ? 16'd0 : r_pos + 16'd1;
        end else begin
            w_ph_new  = (w_ph_dec == 4'd0 || w_ph_dec > w_top) ? w_top : w_ph_dec;
            w_pos_new = (r_pos == 16'd0 || {1'b0, r_pos} >= w_rev) ?
                        16'((w_rev - 17'd1)) : r_pos - 16'd1;
        end
    end

    assign w_lines_new = (r_lines & ~phase_clr(r_half, w_ph_new)) | phase_set(r_half, w_ph_new);
    assign w_pend_step = w_fwd ? r_pend - PENDING_BITS'(1) : r_pend + PENDING_BITS'(1);

    assign w_above_standstill = (CMP_W'(w_t1) > CMP_W'(r_standstill));
    assign w_below_min        = (CMP_W'(w_t1) < CMP_W'(r_min_step));

    // Planning and recalibration share one saturating adder on the pending count.
    always_comb begin
        priority if (i_in_req.kind == KIND_PLAN_FWD) begin
            w_delta = SUM_W'(1);
        end else if (i_in_req.kind == KIND_PLAN_BWD) begin
            w_delta = {SUM_W{1'b1}};
        end else if (i_in_req.correct_backward) begin
            w_delta = -$signed(SUM_W'(i_in_req.offset_steps));
        end else begin
            w_delta = $signed(SUM_W'(i_in_req.offset_steps));
        end
    end

    assign w_pend_sum = SUM_W'(r_pend) + w_delta;

    always_comb begin
        priority if (w_pend_sum > SUM_W'(P_MAX)) begin
            w_pend_sat = P_MAX;
        end else if (w_pend_sum < SUM_W'(P_MIN)) begin
            w_pend_sat = P_MIN;
        end else begin
            w_pend_sat = w_pend_sum[PENDING_BITS-1:0];
        end
    end

    // Forward correction: (target mod rev - offset mod rev) wrapped into range.
    assign w_combine = (r_tmod >= w_mod_rem) ?
                       {1'b0, r_tmod} - {1'b0, w_mod_rem} :
                       {1'b0, r_tmod} + w_rev - {1'b0, w_mod_rem};

    function automatic t_sss_res build_res(
        input logic [3:0]                     lines,
        input logic                           energized,
        input logic                           stepped,
        input logic [15:0]                    pos,
        input logic                           dir,
        input logic signed [PENDING_BITS-1:0] pend
    );
        t_sss_res res;
        logic signed [31:0] pend_ext;
        pend_ext           = 32'(pend);
        res.coil_lines     = lines;
        res.coils_on       = energized;
        res.stepped        = stepped;
        res.position       = pos;
        res.moving_forward = dir;
        res.steps_pending  = pend_ext[15:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sequencer. Simple requests update the state on acceptance and load
    // the result at once if the output register is free; otherwise the
    // result is rebuilt from the state in the hold state. Recalibration
    // runs the remainder unit once or twice before the hold state.
    // ------------------------------------------------------------------
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_phase       = r_phase;
        n_lines       = r_lines;
        n_energized   = r_energized;
        n_pos         = r_pos;
        n_pend        = r_pend;
        n_ticks       = r_ticks;
        n_dir         = r_dir;
        n_state       = r_state;
        n_stepped     = r_stepped;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        n_offset      = r_offset;
        n_backward    = r_backward;
        n_tmod        = r_tmod;
        w_mod_start   = 1'b0;
        w_mod_dvd     = '0;
        w_stepped_now = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_req.kind)
                        KIND_TICK: begin
                            n_ticks = w_t1;
                            priority if (!r_energized && w_pend_zero) begin
                                n_ticks = w_t1;
                            end else if (w_pend_zero && w_above_standstill) begin
                                // Standstill: release the coils and be ready to step.
                                n_lines     = 4'h0;
                                n_energized = 1'b0;
                                n_ticks     = '1;
                            end else if (w_below_min) begin
                                n_ticks = w_t1;
                            end else if (!w_pend_zero) begin
                                n_phase       = w_ph_new;
                                n_lines       = w_lines_new;
                                n_energized   = 1'b1;
                                n_pos         = w_pos_new;
                                n_dir         = w_fwd;
                                n_pend        = w_pend_step;
                                n_ticks       = '0;
                                w_stepped_now = 1'b1;
                            end else begin
                                n_ticks = w_t1;
                            end
                        end
                        KIND_PLAN_FWD, KIND_PLAN_BWD: begin
                            n_pend = w_pend_sat;
                        end
                        KIND_RECAL: begin
                            n_pend      = w_pend_sat;
                            n_offset    = i_in_req.offset_steps;
                            n_backward  = i_in_req.correct_backward;
                            w_mod_start = 1'b1;
                            w_mod_dvd   = i_in_req.correct_backward ?
                                          {1'b0, i_in_req.target_position} +
                                          {1'b0, i_in_req.offset_steps} :
                                          {1'b0, i_in_req.target_position};
                        end
                        KIND_RESET: begin
                            n_pos       = 16'd0;
                            n_ticks     = '1;
                            n_pend      = '0;
                            n_lines     = 4'h0;
                            n_energized = 1'b0;
                        end
                        default: begin
                            n_pend = r_pend;
                        end
                    endcase

                    if (i_in_req.kind == KIND_RECAL) begin
                        n_stepped = 1'b0;
                        n_state   = S_MOD_A;
                    end else if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = build_res(n_lines, n_energized, w_stepped_now,
                                                n_pos, n_dir, n_pend);
                    end else begin
                        n_stepped = w_stepped_now;
                        n_state   = S_HOLD;
                    end
                end
            end
            S_MOD_A: begin
                if (w_mod_done) begin
                    if (r_backward) begin
                        n_pos   = w_mod_rem;
                        n_state = S_HOLD;
                    end else begin
                        n_tmod      = w_mod_rem;
                        w_mod_start = 1'b1;
                        w_mod_dvd   = {1'b0, r_offset};
                        n_state     = S_MOD_B;
                    end
                end
            end
            S_MOD_B: begin
                if (w_mod_done) begin
                    n_pos   = w_combine[15:0];
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = build_res(r_lines, r_energized, r_stepped,
                                            r_pos, r_dir, r_pend);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 4'd1;
            r_lines     <= 4'h0;
            r_energized <= 1'b0;
            r_pos       <= 16'd0;
            r_pend      <= '0;
            r_ticks     <= '1;
            r_dir       <= 1'b0;
            r_state     <= S_IDLE;
            r_stepped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_lines     <= n_lines;
            r_energized <= n_energized;
            r_pos       <= n_pos;
            r_pend      <= n_pend;
            r_ticks     <= n_ticks;
            r_dir       <= n_dir;
            r_state     <= n_state;
            r_stepped   <= n_stepped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_offset   <= n_offset;
        r_backward <= n_backward;
        r_tmod     <= n_tmod;
    end

    sss_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (w_rev),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

// ===== tb/sv/stepper_step_sequencer_unit_test.sv =====
// Self-checking testbench of the stepper step sequencer: directed table, then random requests.
`timescale 1ns / 1ps

// Requests go in on one valid/stall channel and results come back on the other.
// Each request produces exactly one result. A predictor of the sequencer, with
// its own copy of the state and the four registers, works out the result of
// every request at the edge where it is accepted. It queues that result, and
// the result monitor compares each delivered result with the oldest queued one,
// field by field.
//
// The run has a short directed table first. Its early rows carry results typed
// in by hand. Its later rows change the registers to reach phase wrap, position
// wrap and the coil switch-off. Eight random phases follow, each under its own
// register setting, extremes included. Registers are only written once every
// queued result has arrived, so the block is idle.
module stepper_step_sequencer_unit_test;
    import sss_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 5;
    // Idle settling after the last queued result has arrived.
    localparam int SETTLE_CYCLES    = 4;
    localparam int TAIL_CYCLES      = 40;
    localparam int HOLD_OFF_CYCLES  = 120;
    localparam int IDLE_LIMIT       = 4000;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_REQUESTS   = 165;
    localparam int REPORT_LIMIT     = 10;
    localparam int PENDING_TOP      = (1 << (PENDING_BITS_DEF - 1)) - 1;
    localparam int PENDING_BOTTOM   = -PENDING_TOP - 1;
    localparam logic [23:0] TICKS_FULL = '1;

    // Coil tables, one nibble per phase with phase 0 in the lowest nibble.
    localparam logic [35:0] HALF_ON    = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h0};
    localparam logic [35:0] HALF_OFF   = {4'h0, 4'h5, 4'h0, 4'hA, 4'h0, 4'h5, 4'h0, 4'hA, 4'h0};
    localparam logic [19:0] SINGLE_ON  = {4'h8, 4'h4, 4'h2, 4'h1, 4'h0};
    localparam logic [19:0] SINGLE_OFF = {4'h5, 4'hA, 4'h5, 4'hA, 4'h0};

    // One row of the directed table: either a register write or a request.
    // A request row with typed set carries its result written out by hand.
    typedef struct packed {
        logic        is_write;
        logic [1:0]  reg_index;
        logic [31:0] reg_value;
        t_sss_req    req;
        logic        typed;
        t_sss_res    res;
    } t_script_row;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_sss_req    in_req    = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_sss_res    out_res;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the registers.
    logic [23:0] cfg_min_step;
    logic [23:0] cfg_standstill;
    logic        cfg_half;
    logic [15:0] cfg_rev;

    // Predictor copy of the sequencer state.
    logic [3:0]  st_phase;
    logic [3:0]  st_lines;
    logic        st_energised;
    logic [15:0] st_position;
    int          st_pending;
    logic [23:0] st_ticks;
    logic        st_forward;

    t_sss_res    reports_due[$];
    t_script_row script[$];
    int          mismatches      = 0;
    int          results_seen    = 0;
    int          idle_cycles     = 0;
    int          src_burst       = 0;
    int          sink_burst      = 0;
    bit          hold_off_wanted = 1'b0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    stepper_step_sequencer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void load_reset_state();
        cfg_min_step   = MIN_STEP_RST;
        cfg_standstill = STANDSTILL_RST;
        cfg_half       = HALF_MODE_RST;
        cfg_rev        = STEPS_REV_RST;
        st_phase       = 4'd1;
        st_lines       = 4'h0;
        st_energised   = 1'b0;
        st_position    = 16'd0;
        st_pending     = 0;
        st_ticks       = TICKS_FULL;
        st_forward     = 1'b0;
    endfunction

    // The pending count saturates at the signed range of the block's counter.
    function automatic void add_to_pending(input int delta);
        int v;
        v = st_pending + delta;
        if (v > PENDING_TOP) v = PENDING_TOP;
        if (v < PENDING_BOTTOM) v = PENDING_BOTTOM;
        st_pending = v;
    endfunction

    // A revolution size of zero stands for the full 16-bit range.
    function automatic int revolution();
        return (cfg_rev == 16'd0) ? 65536 : int'(cfg_rev);
    endfunction

    // Lines not named by the phase keep their level; a phase outside the table
    // changes no line but still energises the coils.
    function automatic void energise_phase();
        int idx;
        idx = int'(st_phase);
        st_energised = 1'b1;
        if (cfg_half) begin
            if (idx >= 1 && idx <= 8)
                st_lines = (st_lines & ~HALF_OFF[idx*4 +: 4]) | HALF_ON[idx*4 +: 4];
        end else begin
            if (idx >= 1 && idx <= 4)
                st_lines = (st_lines & ~SINGLE_OFF[idx*4 +: 4]) | SINGLE_ON[idx*4 +: 4];
        end
    endfunction

    // One motor step. A phase left out of range by a mode change restarts at phase
    // 1 going forward or at the last phase going backward, and a position at or past the revolution size wraps.
    function automatic void take_step(input logic fwd);
        int top;
        int rev;
        int pos;
        logic [3:0] ph;
        top = cfg_half ? 8 : 4;
        rev = revolution();
        pos = int'(st_position);
        if (fwd) begin
            ph = st_phase + 4'd1;
            if (ph > top || ph < 1) ph = 4'd1;
            pos = (pos >= rev - 1) ? 0 : pos + 1;
        end else begin
            ph = st_phase - 4'd1;
            if (ph < 1 || ph > top) ph = 4'(top);
            pos = (pos == 0 || pos >= rev) ? rev - 1 : pos - 1;
        end
        st_phase    = ph;
        st_position = 16'(pos);
        energise_phase();
        st_forward  = fwd;
    endfunction

    // A tick: count it, switch the coils off after the standstill delay, or
    // make one pending step once the minimum step delay has passed.
    function automatic logic advance_tick();
        if (st_ticks != TICKS_FULL) st_ticks = st_ticks + 24'd1;
        if (!st_energised && st_pending == 0) return 1'b0;
        if (st_pending == 0 && st_ticks > cfg_standstill) begin
            st_lines     = 4'h0;
            st_energised = 1'b0;
            st_ticks     = TICKS_FULL;
            return 1'b0;
        end
        if (st_ticks < cfg_min_step || st_pending == 0) return 1'b0;
        if (st_pending < 0) begin
            take_step(1'b0);
            st_pending = st_pending + 1;
        end else begin
            take_step(1'b1);
            st_pending = st_pending - 1;
        end
        st_ticks = '0;
        return 1'b1;
    endfunction

    function automatic t_sss_res sequence_request(input t_sss_req r);
        t_sss_res res;
        logic moved;
        int rev;
        int tgt;
        int ofs;
        moved = 1'b0;
        rev   = revolution();
        tgt   = int'(r.target_position);
        ofs   = int'(r.offset_steps);
        case (r.kind)
            KIND_TICK:     moved = advance_tick();
            KIND_PLAN_FWD: add_to_pending(1);
            KIND_PLAN_BWD: add_to_pending(-1);
            KIND_RECAL: begin
                // Correcting backward means the hand is ahead of the target.
                if (r.correct_backward) begin
                    add_to_pending(-ofs);
                    st_position = 16'((tgt + ofs) % rev);
                end else begin
                    add_to_pending(ofs);
                    st_position = 16'(((tgt % rev) + rev - (ofs % rev)) % rev);
                end
            end
            KIND_RESET: begin
                st_position  = 16'd0;
                st_ticks     = TICKS_FULL;
                st_pending   = 0;
                st_lines     = 4'h0;
                st_energised = 1'b0;
            end
            default: ;
        endcase
        res.coil_lines     = st_lines;
        res.coils_on       = st_energised;
        res.stepped        = moved;
        res.position       = st_position;
        res.moving_forward = st_forward;
        res.steps_pending  = 16'(st_pending);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request after a drawn gap. The gap is skipped during a burst.
    // Valid stays high from one request to the next when there is no gap.
    task automatic offer_request(input t_sss_req r, input logic typed, input t_sss_res hand_res);
        int gap;
        t_sss_res predicted;
        if (src_burst > 0) begin
            gap = 0;
            src_burst--;
        end else if ($urandom_range(0, 24) == 0) begin
            gap = 0;
            src_burst = 30;
        end else begin
            gap = $urandom_range(0, 3);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge i_clk); while (in_stall);
        predicted = sequence_request(r);
        reports_due.push_back(typed ? hand_res : predicted);
    endtask

    // Stops offering and waits for every queued result; the block is then idle.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge
    // where the access cycle meets pready. The port then goes idle, so that the
    // next write starts its setup cycle at a fresh edge.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_MIN_STEP:   cfg_min_step   = value[23:0];
            REG_STANDSTILL: cfg_standstill = value[23:0];
            REG_HALF_MODE:  cfg_half       = value[0];
            REG_STEPS_REV:  cfg_rev        = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [23:0] min_step, input logic [23:0] standstill,
                                 input logic half, input logic [15:0] rev);
        wait_until_idle();
        write_register(REG_MIN_STEP, {8'h00, min_step});
        write_register(REG_STANDSTILL, {8'h00, standstill});
        write_register(REG_HALF_MODE, {31'd0, half});
        write_register(REG_STEPS_REV, {16'h0000, rev});
    endtask

    function automatic t_sss_req make_req(input logic [2:0] kind, input logic [15:0] tgt,
                                          input logic [15:0] ofs, input logic back);
        t_sss_req r;
        r.kind             = kind;
        r.target_position  = tgt;
        r.offset_steps     = ofs;
        r.correct_backward = back;
        return r;
    endfunction

    task automatic row_request(input logic [2:0] kind, input logic [15:0] tgt,
                               input logic [15:0] ofs, input logic back);
        t_script_row row;
        row     = '0;
        row.req = make_req(kind, tgt, ofs, back);
        script.push_back(row);
    endtask

    task automatic row_typed(input logic [2:0] kind, input logic [15:0] tgt,
                             input logic [15:0] ofs, input logic back,
                             input logic [3:0] lines, input logic on, input logic moved,
                             input logic [15:0] pos, input logic fwd, input int pend);
        t_script_row row;
        row                    = '0;
        row.req                = make_req(kind, tgt, ofs, back);
        row.typed              = 1'b1;
        row.res.coil_lines     = lines;
        row.res.coils_on       = on;
        row.res.stepped        = moved;
        row.res.position       = pos;
        row.res.moving_forward = fwd;
        row.res.steps_pending  = 16'(pend);
        script.push_back(row);
    endtask

    task automatic row_write(input logic [1:0] index, input logic [31:0] value);
        t_script_row row;
        row           = '0;
        row.is_write  = 1'b1;
        row.reg_index = index;
        row.reg_value = value;
        script.push_back(row);
    endtask

    // Random request: mostly ticks so that planned steps really get made, with
    // plans, recalibrations, resets and a few unused kinds mixed in. Offsets are
    // mostly small; now and then a full-range one drives the count to saturation.
    function automatic t_sss_req draw_request();
        t_sss_req r;
        int roll;
        roll               = $urandom_range(0, 99);
        r.target_position  = 16'($urandom);
        r.offset_steps     = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 20));
        r.correct_backward = 1'($urandom_range(0, 1));
        if (roll < 62)      r.kind = KIND_TICK;
        else if (roll < 74) r.kind = KIND_PLAN_FWD;
        else if (roll < 84) r.kind = KIND_PLAN_BWD;
        else if (roll < 92) r.kind = KIND_RECAL;
        else if (roll < 96) r.kind = KIND_RESET;
        else                r.kind = 3'($urandom_range(5, 7));
        return r;
    endfunction

    // Register settings of the random phases, extremes among them.
    task automatic apply_setting(input int idx);
        case (idx)
            0:       write_setting(24'd3, 24'd40, 1'b1, 16'd200);
            1:       write_setting(24'd0, 24'd0, 1'b0, 16'd1);
            2:       write_setting(24'hFFFFFF, 24'hFFFFFF, 1'b1, 16'd65535);
            3:       write_setting(24'd2, 24'hFFFFFF, 1'b0, 16'd0);
            4:       write_setting(24'd1, 24'd10, 1'b1, 16'd7);
            5:       write_setting(24'd5, 24'd100, 1'b0, 16'd65535);
            6:       write_setting(24'd0, 24'd3, 1'b1, 16'd12);
            default: write_setting(24'd1, 24'd6, 1'b0, 16'd50);
        endcase
    endtask

    initial begin : request_source
        t_script_row row;
        load_reset_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Under the reset settings. The tick count stays saturated until the first
        // step, so the planned step is made on the first tick after the plan.
        row_typed(KIND_TICK, 16'd0, 16'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'd0, 1'b0, 0);
        row_typed(KIND_PLAN_FWD, 16'd0, 16'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'd0, 1'b0, 1);
        row_typed(KIND_TICK, 16'd0, 16'd0, 1'b0, 4'h3, 1'b1, 1'b1, 16'd1, 1'b1, 0);
        row_typed(KIND_PLAN_BWD, 16'd0, 16'd0, 1'b0, 4'h3, 1'b1, 1'b0, 16'd1, 1'b1, -1);
        // An unused kind changes nothing and reports the state.
        row_typed(3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 4'h3, 1'b1, 1'b0, 16'd1, 1'b1, -1);
        // A reset request keeps the direction of the last step.
        row_typed(KIND_RESET, 16'd0, 16'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'd0, 1'b1, 0);
        // Full-range offsets drive the pending count into both saturation limits.
        row_typed(KIND_RECAL, 16'hFFFF, 16'hFFFF, 1'b1, 4'h0, 1'b0, 1'b0, 16'd4094, 1'b1, -32768);
        row_typed(KIND_PLAN_BWD, 16'd0, 16'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'd4094, 1'b1, -32768);
        row_typed(KIND_RECAL, 16'd0, 16'hFFFF, 1'b0, 4'h0, 1'b0, 1'b0, 16'd1, 1'b1, 32767);
        row_typed(KIND_PLAN_FWD, 16'd0, 16'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'd1, 1'b1, 32767);
        row_typed(KIND_TICK, 16'd0, 16'd0, 1'b0, 4'h2, 1'b1, 1'b1, 16'd2, 1'b1, 32766);
        row_typed(KIND_RESET, 16'd0, 16'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'd0, 1'b1, 0);
        // A backward correction wraps past the top of the revolution to zero,
        // and the backward step from zero lands on the last position.
        row_typed(KIND_RECAL, 16'd4095, 16'd1, 1'b1, 4'h0, 1'b0, 1'b0, 16'd0, 1'b1, -1);
        row_typed(KIND_TICK, 16'd0, 16'd0, 1'b0, 4'h3, 1'b1, 1'b1, 16'd4095, 1'b0, 0);

        // A revolution size of zero stands for 65536 positions: stepping forward
        // from the last position wraps to zero and carries the phase past four.
        row_write(REG_MIN_STEP, 32'd0);
        row_write(REG_STANDSTILL, 32'd0);
        row_write(REG_STEPS_REV, 32'd0);
        row_request(KIND_RECAL, 16'd5, 16'd6, 1'b0);
        repeat (4) row_request(KIND_TICK, 16'd0, 16'd0, 1'b0);

        // Single-coil mode on a tiny revolution: the phase and the position are
        // both out of range, and at standstill the coils switch off.
        row_write(REG_HALF_MODE, 32'd0);
        row_write(REG_STEPS_REV, 32'd3);
        row_request(KIND_TICK, 16'd0, 16'd0, 1'b0);
        row_request(KIND_RECAL, 16'd2, 16'd3, 1'b1);
        repeat (4) row_request(KIND_TICK, 16'd0, 16'd0, 1'b0);

        while (script.size() != 0) begin
            row = script.pop_front();
            if (row.is_write) begin
                wait_until_idle();
                write_register(row.reg_index, row.reg_value);
            end else begin
                offer_request(row.req, row.typed, row.res);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            apply_setting(ph);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // A long hold-off at the result side fills the block so that it
                // stalls its requests, while this side keeps offering.
                if (ph == 0 && n == 40) hold_off_wanted = 1'b1;
                // Once the source itself pauses until the block has drained.
                if (ph == 3 && n == 80) wait_until_idle();
                offer_request(draw_request(), 1'b0, '0);
            end
        end

        wait_until_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Draws a random stall before each result, with bursts of
    // no stall at all and one long hold-off when the source asks for it.
    initial begin : result_sink
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_wanted) begin
                hold = HOLD_OFF_CYCLES;
                hold_off_wanted = 1'b0;
            end else if (sink_burst > 0) begin
                hold = 0;
                sink_burst--;
            end else if ($urandom_range(0, 24) == 0) begin
                hold = 0;
                sink_burst = 30;
            end else begin
                hold = $urandom_range(0, 3);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_sss_res want;
        logic bad;
        if (i_rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Result %0d arrived with no request waiting for it", results_seen);
            end else begin
                want = reports_due.pop_front();
                bad = (out_res.coil_lines !== want.coil_lines)
                    || (out_res.coils_on !== want.coils_on)
                    || (out_res.stepped !== want.stepped)
                    || (out_res.position !== want.position)
                    || (out_res.moving_forward !== want.moving_forward)
                    || (out_res.steps_pending !== want.steps_pending);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Result %0d differs: expected lines %h on %b stepped %b ",
                                 results_seen, want.coil_lines, want.coils_on, want.stepped,
                                 "pos %0d fwd %b pending %0d, ",
                                 want.position, want.moving_forward, want.steps_pending,
                                 "got lines %h on %b stepped %b ",
                                 out_res.coil_lines, out_res.coils_on, out_res.stepped,
                                 "pos %0d fwd %b pending %0d",
                                 out_res.position, out_res.moving_forward,
                                 out_res.steps_pending);
                end
            end
        end
    end

    // Ends the run if neither a request nor a result moves for too long.
    always @(posedge i_clk) begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: nothing moved for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
